// File: hw/rtl/rsfc_pkg.sv
// ---------------------------------------------------------------------------
// rsfc_pkg
// Shared types and constants for the RGB sensor frequency color classifier.
// ---------------------------------------------------------------------------
package rsfc_pkg;

    localparam int WIN_W     = 16;
    localparam int SET_W     = 8;
    localparam int MS_W      = 16;
    localparam int HZ_W      = 26;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int IN_W      = 8;
    localparam int OUT_W     = 88;
    localparam int FREQ_SCALE = 1000;
    localparam int SCALE_BITS = 10;     // bits needed for FREQ_SCALE

    localparam logic [HZ_W-1:0] HZ_MAX = '1;

    localparam logic [WIN_W-1:0] WIN_RST = 16'd100;
    localparam logic [SET_W-1:0] SET_RST = 8'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd2;

    // measurement phase
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SETTLE = 2'd1;
    localparam logic [1:0] PH_COUNT  = 2'd2;

    // channel / class codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // filter select pin codes (S2, S3)
    localparam logic [1:0] PIN_RED   = 2'd0;
    localparam logic [1:0] PIN_GREEN = 2'd3;
    localparam logic [1:0] PIN_BLUE  = 2'd1;

    typedef struct packed {
        logic step;     // input word accepted
        logic commit;   // divider result written back
        logic load;     // load output register
    } rsfc_cmd_t;

    typedef struct packed {
        logic close;    // accepted word closes a count window
    } rsfc_status_t;

    typedef struct packed {
        logic [HZ_W-1:0] blue_hz;
        logic [HZ_W-1:0] green_hz;
        logic [HZ_W-1:0] red_hz;
        logic [1:0]      color_class;
        logic            done_res;
        logic            busy_res;
        logic [1:0]      filter_pins;
    } rsfc_result_t;

    function automatic logic [1:0] pin_code(input logic [1:0] ch);
        logic [1:0] p;
        unique case (ch)
            CH_RED:   p = PIN_RED;
            CH_GREEN: p = PIN_GREEN;
            default:  p = PIN_BLUE;
        endcase
        return p;
    endfunction

endpackage

// File: hw/rtl/rgb_sensor_freq_color_classifier_core.sv
// Takes one sensor sample word per cycle when not stalled and returns one result word for
// each. A word that closes a channel's count window starts a restoring divider that works
// out its frequency, count * 1000 / gate time, at one quotient bit per cycle (26 quotient
// bits at the default width); no sample is taken until the divider is done and its result
// is written back, which waits while the result side stalls. All other words are loaded
// straight into the result register; a new word enters in the cycle the waiting result
// word is taken, and a stalled result word stalls the input.
// ---------------------------------------------------------------------------
// rgb_sensor_freq_color_classifier_core
// Red/green/blue read sequencer for a light-to-frequency sensor with
// dominant color classification.
// ---------------------------------------------------------------------------
module rgb_sensor_freq_color_classifier_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [rsfc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [rsfc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rsfc_pkg::IN_W-1:0]      s_tdata,  // start_req, pulse_edge, ms_tick
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // filter_pins[1:0], busy_res, done_res, color_class[1:0], red_hz, green_hz, blue_hz
    output logic [rsfc_pkg::OUT_W-1:0]     m_tdata
);
    import rsfc_pkg::*;

    localparam int PW = COUNT_BITS + SCALE_BITS;

    rsfc_cmd_t    cmd;
    rsfc_status_t status;
    rsfc_result_t result;
    logic          div_start;
    logic          div_done;
    logic [PW-1:0] prod;
    logic [PW-1:0] quotient;
    logic [WIN_W-1:0] win;

    rsfc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .status    (status),
        .div_done  (div_done),
        .div_start (div_start),
        .cmd       (cmd)
    );

    rsfc_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .start_req  (s_tdata[0]),
        .pulse_edge (s_tdata[1]),
        .ms_tick    (s_tdata[2]),
        .cmd        (cmd),
        .status     (status),
        .prod       (prod),
        .win        (win),
        .quotient   (quotient),
        .result     (result)
    );

    rsfc_div #(
        .DW (PW),
        .VW (WIN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod),
        .divisor  (win),
        .done     (div_done),
        .quotient (quotient)
    );

    assign m_tdata = {{(OUT_W - $bits(rsfc_result_t)){1'b0}}, result};

endmodule

// File: hw/rtl/rsfc_div.sv
// ---------------------------------------------------------------------------
// rsfc_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rsfc_div #(
    parameter int DW = 26,
    parameter int VW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] div_reg, div_next;
    logic [VW:0]   rem_sh;
    logic [VW:0]   rem_sub;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        rem_sh    = {rem_reg, quo_reg[DW-1]};
        rem_sub   = rem_sh - {1'b0, div_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, div_reg}) begin
                rem_next = rem_sub[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/rsfc_datapath.sv
// ---------------------------------------------------------------------------
// rsfc_datapath
// Config registers, measurement counters, channel results, output register.
// ---------------------------------------------------------------------------
module rsfc_datapath #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [rsfc_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [rsfc_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  start_req,
    input  logic                                  pulse_edge,
    input  logic                                  ms_tick,
    input  rsfc_pkg::rsfc_cmd_t                   cmd,
    output rsfc_pkg::rsfc_status_t                status,
    output logic [COUNT_BITS+rsfc_pkg::SCALE_BITS-1:0] prod,
    output logic [rsfc_pkg::WIN_W-1:0]            win,
    input  logic [COUNT_BITS+rsfc_pkg::SCALE_BITS-1:0] quotient,
    output rsfc_pkg::rsfc_result_t                result
);
    import rsfc_pkg::*;

    localparam int PW = COUNT_BITS + SCALE_BITS;
    localparam int QW = (PW > HZ_W) ? PW : HZ_W;

    logic [WIN_W-1:0]      window_reg;
    logic [SET_W-1:0]      settle_reg;
    logic [1:0]            phase_reg, phase_next;
    logic [1:0]            channel_reg, channel_next;
    logic [MS_W-1:0]       ms_count_reg, ms_count_next;
    logic [COUNT_BITS-1:0] edge_count_reg, edge_count_next;
    logic [HZ_W-1:0]       red_reg, red_next;
    logic [HZ_W-1:0]       green_reg, green_next;
    logic [HZ_W-1:0]       blue_reg, blue_next;
    logic [1:0]            class_reg, class_next;
    logic                  done_next;
    rsfc_result_t          result_reg;

    logic [WIN_W-1:0]      win_eff;
    logic [MS_W-1:0]       ms_inc;
    logic [COUNT_BITS-1:0] edge_inc;
    logic                  close;
    logic [QW-1:0]         q_ext;
    logic [HZ_W-1:0]       hz;

    // scale register writes are not kept; nothing here depends on the scale code
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WIN_RST;
            settle_reg <= SET_RST;
        end else if (cfg_we) begin
            if (cfg_addr == REG_WINDOW) begin
                window_reg <= cfg_data[WIN_W-1:0];
            end
            if (cfg_addr == REG_SETTLE) begin
                settle_reg <= cfg_data[SET_W-1:0];
            end
        end
    end

    always_comb begin
        win_eff  = (window_reg == '0) ? WIN_W'(1) : window_reg;
        ms_inc   = ms_count_reg + MS_W'(1);
        edge_inc = pulse_edge ? edge_count_reg + COUNT_BITS'(1) : edge_count_reg;
        close    = (phase_reg == PH_COUNT) && ms_tick && (ms_inc >= win_eff);
        q_ext    = QW'(quotient);
        hz       = (q_ext > QW'(HZ_MAX)) ? HZ_MAX : q_ext[HZ_W-1:0];

        phase_next      = phase_reg;
        channel_next    = channel_reg;
        ms_count_next   = ms_count_reg;
        edge_count_next = edge_count_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        class_next      = class_reg;
        done_next       = 1'b0;

        if (cmd.step) begin
            unique case (phase_reg)
                PH_SETTLE: begin
                    if (ms_tick) begin
                        ms_count_next = ms_inc;
                        if (ms_inc >= MS_W'(settle_reg)) begin
                            ms_count_next   = '0;
                            edge_count_next = '0;
                            phase_next      = PH_COUNT;
                        end
                    end
                end
                PH_COUNT: begin
                    // a closing word is finished by the write-back
                    if (!close) begin
                        edge_count_next = edge_inc;
                        if (ms_tick) begin
                            ms_count_next = ms_inc;
                        end
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    if (start_req) begin
                        channel_next    = CH_RED;
                        ms_count_next   = '0;
                        edge_count_next = '0;
                        phase_next      = (settle_reg == '0) ? PH_COUNT : PH_SETTLE;
                    end
                end
            endcase
        end

        if (cmd.commit) begin
            ms_count_next   = '0;
            edge_count_next = '0;
            phase_next      = (settle_reg == '0) ? PH_COUNT : PH_SETTLE;
            unique case (channel_reg)
                CH_RED: begin
                    red_next     = hz;
                    channel_next = CH_GREEN;
                end
                CH_GREEN: begin
                    green_next   = hz;
                    channel_next = CH_BLUE;
                end
                default: begin
                    blue_next  = hz;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                    // ties favor red, then green
                    if (red_reg >= green_reg && red_reg >= hz) begin
                        class_next = CH_RED;
                    end else if (green_reg >= red_reg && green_reg >= hz) begin
                        class_next = CH_GREEN;
                    end else begin
                        class_next = CH_BLUE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            channel_reg    <= CH_RED;
            ms_count_reg   <= '0;
            edge_count_reg <= '0;
            red_reg        <= '0;
            green_reg      <= '0;
            blue_reg       <= '0;
            class_reg      <= CH_RED;
        end else begin
            phase_reg      <= phase_next;
            channel_reg    <= channel_next;
            ms_count_reg   <= ms_count_next;
            edge_count_reg <= edge_count_next;
            red_reg        <= red_next;
            green_reg      <= green_next;
            blue_reg       <= blue_next;
            class_reg      <= class_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            result_reg.filter_pins <= pin_code(channel_next);
            result_reg.busy_res    <= (phase_next != PH_IDLE);
            result_reg.done_res    <= done_next;
            result_reg.color_class <= class_next;
            result_reg.red_hz      <= red_next;
            result_reg.green_hz    <= green_next;
            result_reg.blue_hz     <= blue_next;
        end
    end

    assign status.close = close;
    assign prod   = PW'(edge_inc) * PW'(FREQ_SCALE);
    assign win    = win_eff;
    assign result = result_reg;

endmodule

// File: hw/rtl/rsfc_ctrl.sv
// ---------------------------------------------------------------------------
// rsfc_ctrl
// Handshake controller: input acceptance, divider sequencing, output valid.
// ---------------------------------------------------------------------------
module rsfc_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  rsfc_pkg::rsfc_status_t status,
    input  logic                   div_done,
    output logic                   div_start,
    output rsfc_pkg::rsfc_cmd_t    cmd
);
    import rsfc_pkg::*;

    localparam logic [1:0] CS_RUN = 2'd0;
    localparam logic [1:0] CS_DIV = 2'd1;
    localparam logic [1:0] CS_WB  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    always_comb begin
        out_free   = !m_valid_reg || m_tready;
        s_tready   = (state_reg == CS_RUN) && out_free;
        cmd.step   = s_tvalid && s_tready;
        cmd.commit = (state_reg == CS_WB) && out_free;
        cmd.load   = (cmd.step && !status.close) || cmd.commit;
        div_start  = cmd.step && status.close;

        state_next = state_reg;
        unique case (state_reg)
            CS_RUN: begin
                if (div_start) begin
                    state_next = CS_DIV;
                end
            end
            CS_DIV: begin
                if (div_done) begin
                    state_next = CS_WB;
                end
            end
            CS_WB: begin
                if (out_free) begin
                    state_next = CS_RUN;
                end
            end
            default: begin
                state_next = CS_RUN;
            end
        endcase

        m_valid_next = m_valid_reg;
        if (cmd.load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_RUN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

// File: hw/rtl/rsfc_checker.sv
// ---------------------------------------------------------------------------
// rsfc_checker
// Port-level checks for the color classifier core.
// ---------------------------------------------------------------------------
module rsfc_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [rsfc_pkg::OUT_W-1:0] m_tdata
);
    import rsfc_pkg::*;

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // no new word taken while a result is blocked
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output register blocked");

    // completion word shows the sequence already ended
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
        else $error("done with busy still set");

    a_class_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[5:4] != 2'd3)
        else $error("invalid color class");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind rgb_sensor_freq_color_classifier_core rsfc_checker u_rsfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/rgb_sensor_freq_color_classifier_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rgb_sensor_freq_color_classifier_core_tb
// Streams sensor sample words (start, edge, ms tick) into the color read
// sequencer. A cycle-free model of the red/green/blue gated counter predicts
// every result word, and the monitor compares each one field by field.
// The run covers reset settings, directed corner cases and randomized reads
// under varied register settings, with random handshake gaps on both sides
// and one long output stall.
// ---------------------------------------------------------------------------
module rgb_sensor_freq_color_classifier_core_tb;
    import rsfc_pkg::*;

    localparam int COUNT_BITS = 16;

    typedef struct packed {
        logic ms_tick;
        logic pulse_edge;
        logic start_req;
    } sample_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata  = '0;  // start_req, pulse_edge, ms_tick
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // filter_pins[1:0], busy_res, done_res, color_class[1:0], red_hz, green_hz, blue_hz
    logic [OUT_W-1:0]     m_tdata;

    rgb_sensor_freq_color_classifier_core #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_we  (cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // sequencer shadow state and register copies
    logic [1:0]            cur_phase  = PH_IDLE;
    logic [1:0]            cur_chan   = CH_RED;
    logic [MS_W-1:0]       ms_cnt     = '0;
    logic [COUNT_BITS-1:0] edge_cnt   = '0;
    logic [HZ_W-1:0]       red_val    = '0;
    logic [HZ_W-1:0]       green_val  = '0;
    logic [HZ_W-1:0]       blue_val   = '0;
    logic [1:0]            cur_class  = CH_RED;
    logic [WIN_W-1:0]      win_cfg    = WIN_RST;
    logic [SET_W-1:0]      settle_cfg = SET_RST;

    sample_t      sample_queue[$];
    rsfc_result_t predicted_words[$];

    bit gaps_on        = 1'b1;
    bit long_hold_done = 1'b0;
    int unsigned tx_wait, rx_wait;
    int unsigned words_sent, words_checked, reads_done, reg_writes, fail_count;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Timeout: %0d words sent, %0d checked", words_sent, words_checked);
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------- prediction ----------------

    task automatic open_channel(input logic [1:0] ch);
        cur_chan  = ch;
        ms_cnt    = '0;
        edge_cnt  = '0;
        cur_phase = (settle_cfg == '0) ? PH_COUNT : PH_SETTLE;
    endtask

    task automatic step_sequencer(input sample_t s, output rsfc_result_t r);
        logic [WIN_W-1:0] win;
        logic [63:0]      freq;
        logic [HZ_W-1:0]  hz;
        logic             fin;
        fin = 1'b0;
        win = (win_cfg == '0) ? WIN_W'(1) : win_cfg;
        case (cur_phase)
            PH_SETTLE: begin
                if (s.ms_tick) begin
                    ms_cnt = ms_cnt + 1'b1;
                    if (ms_cnt >= settle_cfg) begin
                        ms_cnt    = '0;
                        edge_cnt  = '0;
                        cur_phase = PH_COUNT;
                    end
                end
            end
            PH_COUNT: begin
                // an edge on the closing tick still counts
                if (s.pulse_edge)
                    edge_cnt = edge_cnt + 1'b1;
                if (s.ms_tick) begin
                    ms_cnt = ms_cnt + 1'b1;
                    if (ms_cnt >= win) begin
                        freq = 64'(edge_cnt) * 64'(FREQ_SCALE) / 64'(win);
                        hz   = (freq > 64'(HZ_MAX)) ? HZ_MAX : freq[HZ_W-1:0];
                        case (cur_chan)
                            CH_RED: begin
                                red_val = hz;
                                open_channel(CH_GREEN);
                            end
                            CH_GREEN: begin
                                green_val = hz;
                                open_channel(CH_BLUE);
                            end
                            default: begin
                                blue_val = hz;
                                // ties: red wins, then green
                                if (red_val >= green_val && red_val >= blue_val)
                                    cur_class = CH_RED;
                                else if (green_val >= blue_val)
                                    cur_class = CH_GREEN;
                                else
                                    cur_class = CH_BLUE;
                                cur_phase = PH_IDLE;
                                ms_cnt    = '0;
                                fin       = 1'b1;
                            end
                        endcase
                    end
                end
            end
            default: begin
                // start word only selects red; its edge and tick are dropped
                if (s.start_req)
                    open_channel(CH_RED);
            end
        endcase
        r.filter_pins = (cur_chan == CH_RED)   ? PIN_RED :
                        (cur_chan == CH_GREEN) ? PIN_GREEN : PIN_BLUE;
        r.busy_res    = (cur_phase != PH_IDLE);
        r.done_res    = fin;
        r.color_class = cur_class;
        r.red_hz      = red_val;
        r.green_hz    = green_val;
        r.blue_hz     = blue_val;
    endtask

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap(input bit on);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------- driver ----------------

    always @(posedge aclk) begin : sample_driver
        rsfc_result_t want;
        sample_t      nxt;
        logic         nv;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            tx_wait  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                step_sequencer(sample_t'(s_tdata[2:0]), want);
                predicted_words.push_back(want);
                words_sent++;
                if (want.done_res)
                    reads_done++;
            end
            if (!(s_tvalid && !s_tready)) begin
                nv  = 1'b0;
                nxt = '0;
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (sample_queue.size() > 0) begin
                    nxt     = sample_queue.pop_front();
                    nv      = 1'b1;
                    tx_wait = pick_gap(gaps_on);
                end
                s_tvalid <= nv;
                s_tdata  <= {{(IN_W-3){1'b0}}, nxt};
            end
        end
    end

    // ---------------- monitor ----------------

    task automatic check_field(input string fld, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (fail_count < 40)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        rsfc_result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = rsfc_result_t'(m_tdata[$bits(rsfc_result_t)-1:0]);
                words_checked++;
                if (predicted_words.size() == 0) begin
                    $display("%0t: result word with none expected, actual %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = predicted_words.pop_front();
                    check_field("filter_pins", want.filter_pins, got.filter_pins);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("color_class", want.color_class, got.color_class);
                    check_field("red_hz", want.red_hz, got.red_hz);
                    check_field("green_hz", want.green_hz, got.green_hz);
                    check_field("blue_hz", want.blue_hz, got.blue_hz);
                end
            end
            // one long hold-off so the output side backs up into the input
            if (!long_hold_done && words_checked >= 200) begin
                long_hold_done = 1'b1;
                rx_wait        = 300;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                rx_wait = pick_gap(gaps_on);
                m_tready <= (rx_wait == 0);
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic push_sample(input bit st, input bit ed, input bit tk);
        sample_queue.push_back({tk, ed, st});
    endtask

    task automatic queue_samples(input int unsigned n, input int unsigned start_pct,
                                 input int unsigned edge_pct, input int unsigned tick_pct);
        for (int unsigned i = 0; i < n; i++)
            push_sample($urandom_range(0, 99) < start_pct, $urandom_range(0, 99) < edge_pct,
                        $urandom_range(0, 99) < tick_pct);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        // the scale code is not kept by the core; no result shows it
        if (idx == REG_WINDOW)
            win_cfg = val[WIN_W-1:0];
        else if (idx == REG_SETTLE)
            settle_cfg = val[SET_W-1:0];
        reg_writes++;
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] settle,
                            input logic [CFG_W-1:0] scale);
        write_reg(REG_WINDOW, win);
        write_reg(REG_SETTLE, settle);
        write_reg(REG_SCALE, scale);
    endtask

    // wait for every word to come back; finish an open read with extra ticks
    task automatic drain_to_idle();
        do begin
            while (sample_queue.size() > 0 || s_tvalid || predicted_words.size() > 0)
                @(negedge aclk);
            if (cur_phase != PH_IDLE)
                queue_samples(64, 0, 50, 100);
        end while (cur_phase != PH_IDLE);
        repeat (8) @(posedge aclk);
    endtask

    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: idle words, then one read at 100 ms gate, 3 ms settle
        push_sample(0, 1, 1);
        push_sample(0, 1, 0);
        push_sample(1, 0, 0);
        queue_samples(330, 0, 50, 100);
        drain_to_idle();

        // zero settle, 2 ms gate; start while busy, edge on closing tick
        set_regs(16'd2, 16'd0, 16'd0);
        push_sample(0, 1, 1);
        push_sample(1, 1, 1);
        push_sample(1, 1, 0);
        push_sample(0, 1, 1);
        push_sample(0, 1, 1);
        push_sample(0, 0, 1);
        push_sample(0, 0, 1);
        push_sample(0, 1, 0);
        push_sample(0, 1, 1);
        push_sample(0, 0, 1);
        drain_to_idle();

        // zero gate acts as 1 ms; red and green tie, red wins
        set_regs(16'd0, 16'd1, 16'd3);
        push_sample(1, 0, 1);
        push_sample(0, 1, 1);
        push_sample(0, 1, 1);
        push_sample(0, 0, 1);
        push_sample(0, 1, 1);
        push_sample(0, 0, 1);
        push_sample(0, 0, 1);
        drain_to_idle();

        // randomized reads with small gates so ties and zero counts show up
        for (int p = 0; p < 4; p++) begin
            gaps_on = (p == 0) || ($urandom_range(0, 3) != 0);
            set_regs(($urandom_range(0, 4) == 0) ? CFG_W'($urandom_range(5, 12))
                                                  : CFG_W'($urandom_range(0, 4)),
                     CFG_W'($urandom_range(0, 3)), CFG_W'($urandom_range(0, 3)));
            push_sample(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            queue_samples(60, 8, 50, 65);
            drain_to_idle();
        end

        repeat (40) @(posedge aclk);
        $display("Checked %0d result words for %0d sample words, %0d complete color reads.",
                 words_checked, words_sent, reads_done);
        $display("%0d register writes: reset, zero and small gates, short settles, %s",
                 reg_writes, "all scale codes, start while busy and color ties.");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
